>>> rtl/core/ihsp_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the image header size parser
package ihsp_pkg;

  // jpeg marker codes
  localparam logic [7:0] MARK_FF  = 8'hFF;
  localparam logic [7:0] SOI_CODE = 8'hD8;
  localparam logic [7:0] EOI_CODE = 8'hD9;
  localparam logic [7:0] SOS_CODE = 8'hDA;
  localparam logic [7:0] SOF_LO   = 8'hC0;
  localparam logic [7:0] SOF_HI   = 8'hCF;
  localparam logic [7:0] DHT_CODE = 8'hC4;
  localparam logic [7:0] JPG_CODE = 8'hC8;
  localparam logic [7:0] DAC_CODE = 8'hCC;

  // ascii signature letters
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_I = 8'h49;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_J = 8'h4A;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_M = 8'h4D;

  // byte offsets within the file
  localparam logic [4:0] OFS_SIG_LAST = 5'd2;
  localparam logic [4:0] OFS_GIF_DIM  = 5'd6;
  localparam logic [4:0] OFS_BMP_DIM  = 5'd18;
  localparam logic [4:0] OFS_BMP_LAST = 5'd25;
  localparam logic [4:0] OFS_MAX      = 5'd31;

  // sof field positions, counted from the length field
  localparam logic [15:0] SOF_H_HI = 16'd3;
  localparam logic [15:0] SOF_H_LO = 16'd4;
  localparam logic [15:0] SOF_W_HI = 16'd5;
  localparam logic [15:0] SOF_W_LO = 16'd6;

  typedef enum logic [2:0] {
    IMG_UNKNOWN = 3'd0,
    IMG_JPEG    = 3'd1,
    IMG_GIF     = 3'd2,
    IMG_BMP     = 3'd3,
    IMG_ART     = 3'd4
  } img_type_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_UNKNOWN_TYPE = 3'd1,
    ST_TRUNCATED    = 3'd2,
    ST_NO_FRAME     = 3'd3,
    ST_BAD_LENGTH   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    PH_SIG     = 4'd0,
    PH_GIF     = 4'd1,
    PH_BMP     = 4'd2,
    PH_JSEARCH = 4'd3,
    PH_JCODE   = 4'd4,
    PH_JLENHI  = 4'd5,
    PH_JLENLO  = 4'd6,
    PH_JSKIP   = 4'd7,
    PH_JSOF    = 4'd8
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    img_type_t          image_type;
    status_t            status;
    logic signed [31:0] width;
    logic signed [31:0] height;
  } result_t;

  function automatic logic is_sof(input logic [7:0] code);
    return (code >= SOF_LO) && (code <= SOF_HI) &&
           (code != DHT_CODE) && (code != JPG_CODE) && (code != DAC_CODE);
  endfunction

endpackage

>>> rtl/core/ihsp_ifs.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for file bytes and parse results
interface ihsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface ihsp_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         image_type;
  logic [2:0]         status;
  logic signed [31:0] width;
  logic signed [31:0] height;

  modport source (output valid, output image_type, output status, output width,
                  output height, input ready);
  modport sink (input valid, input image_type, input status, input width,
                input height, output ready);
endinterface

>>> rtl/core/ihsp_in_reg.sv
`timescale 1ns / 1ps
// input register holding one file byte for the parse stage
module ihsp_in_reg
  import ihsp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  ihsp_byte_if.sink     in_chan,
  input  logic          take,
  output logic          item_vld,
  output in_item_t      item
);

  logic     vld_r;
  in_item_t item_r;
  logic     accept;

  assign in_chan.ready = !vld_r || take;
  assign accept        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (accept) begin
      vld_r <= 1'b1;
    end else if (take) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data_byte   <= in_chan.data_byte;
      item_r.end_of_file <= in_chan.end_of_file;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

>>> rtl/core/ihsp_parse.sv
`timescale 1ns / 1ps
// per-byte parse stage: file state, signature decode and dimension capture
module ihsp_parse
  import ihsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     item_vld,
  input  in_item_t item,
  input  logic     out_free,
  output logic     take,
  output logic     res_load,
  output result_t  res
);

  logic [4:0]  off_r;
  logic [7:0]  sig0_r;
  logic [7:0]  sig1_r;
  img_type_t   type_r, type_p;
  phase_t      phase_r, phase_p, phase_nxt, jph;
  logic [15:0] cnt_r, cnt_p;
  logic [31:0] wacc_r, wacc_p;
  logic [31:0] hacc_r, hacc_p;
  logic        sent_r;

  logic [7:0]  b;
  logic        eof;
  logic        at_sig_end;
  logic        sig_jpeg, sig_gif, sig_art, sig_bmp;
  logic [15:0] len, len_m2, cnt_dec;
  logic [4:0]  bmp_rel;
  logic [1:0]  lane;
  logic        emit_byte, emit;
  img_type_t   r_type;
  status_t     r_stat;
  logic        fire;

  assign b          = item.data_byte;
  assign eof        = item.end_of_file;
  assign at_sig_end = (phase_r == PH_SIG) && (off_r == OFS_SIG_LAST);
  assign sig_jpeg   = (sig0_r == MARK_FF) && (sig1_r == SOI_CODE);
  assign sig_gif    = (sig0_r == CH_G) && (sig1_r == CH_I) && (b == CH_F);
  assign sig_art    = (sig0_r == CH_J) && (sig1_r == CH_G);
  assign sig_bmp    = (sig0_r == CH_B) && (sig1_r == CH_M);
  assign len        = {cnt_r[15:8], b};
  assign len_m2     = len - 16'd2;
  assign cnt_dec    = cnt_r - 16'd1;
  assign bmp_rel    = off_r - OFS_BMP_DIM;
  assign lane       = bmp_rel[1:0];

  // a jpeg signature hands its third byte straight to the marker search
  assign jph = (at_sig_end && sig_jpeg) ? PH_JSEARCH : phase_r;

  // next state
  always_comb begin
    phase_p = phase_r;
    if (!sent_r) begin
      unique case (jph)
        PH_SIG: begin
          if (at_sig_end) begin
            if (sig_gif) begin
              phase_p = PH_GIF;
            end else if (!sig_art && sig_bmp) begin
              phase_p = PH_BMP;
            end
          end
        end
        PH_JSEARCH: begin
          phase_p = (b == MARK_FF) ? PH_JCODE : PH_JSEARCH;
        end
        PH_JCODE: begin
          if (b == MARK_FF) begin
            phase_p = PH_JCODE;
          end else if (is_sof(b)) begin
            phase_p = PH_JSOF;
          end else if ((b == SOS_CODE) || (b == EOI_CODE)) begin
            phase_p = PH_JCODE;
          end else begin
            phase_p = PH_JLENHI;
          end
        end
        PH_JLENHI: phase_p = PH_JLENLO;
        PH_JLENLO: begin
          if (len >= 16'd2) begin
            phase_p = (len_m2 == 16'd0) ? PH_JSEARCH : PH_JSKIP;
          end
        end
        PH_JSKIP: begin
          if (cnt_dec == 16'd0) begin
            phase_p = PH_JSEARCH;
          end
        end
        default: phase_p = phase_r;
      endcase
    end
    phase_nxt = eof ? PH_SIG : phase_p;
  end

  // outputs and datapath
  always_comb begin
    emit_byte = 1'b0;
    r_type    = type_r;
    r_stat    = ST_OK;
    type_p    = type_r;
    cnt_p     = cnt_r;
    wacc_p    = wacc_r;
    hacc_p    = hacc_r;
    if (!sent_r) begin
      if (at_sig_end && sig_jpeg) begin
        type_p = IMG_JPEG;
      end
      case (jph)
        PH_SIG: begin
          if (at_sig_end) begin
            if (sig_gif) begin
              type_p = IMG_GIF;
            end else if (sig_art) begin
              type_p    = IMG_ART;
              emit_byte = 1'b1;
              r_type    = IMG_ART;
            end else if (sig_bmp) begin
              type_p = IMG_BMP;
            end else begin
              emit_byte = 1'b1;
              r_type    = IMG_UNKNOWN;
              r_stat    = ST_UNKNOWN_TYPE;
            end
          end
        end
        PH_GIF: begin
          case (off_r)
            OFS_GIF_DIM:         wacc_p[7:0]  = b;
            OFS_GIF_DIM + 5'd1:  wacc_p[15:8] = b;
            OFS_GIF_DIM + 5'd2:  hacc_p[7:0]  = b;
            OFS_GIF_DIM + 5'd3: begin
              hacc_p[15:8] = b;
              emit_byte    = 1'b1;
              r_type       = IMG_GIF;
            end
            default: ;
          endcase
        end
        PH_BMP: begin
          if ((off_r >= OFS_BMP_DIM) && (off_r <= OFS_BMP_DIM + 5'd3)) begin
            wacc_p[{lane, 3'b000} +: 8] = b;
          end else if ((off_r >= OFS_BMP_DIM + 5'd4) && (off_r <= OFS_BMP_LAST)) begin
            hacc_p[{lane, 3'b000} +: 8] = b;
            if (off_r == OFS_BMP_LAST) begin
              emit_byte = 1'b1;
              r_type    = IMG_BMP;
            end
          end
        end
        PH_JCODE: begin
          if (b != MARK_FF) begin
            if (is_sof(b)) begin
              cnt_p = 16'd0;
            end else if ((b == SOS_CODE) || (b == EOI_CODE)) begin
              emit_byte = 1'b1;
              r_type    = IMG_JPEG;
              r_stat    = ST_NO_FRAME;
            end
          end
        end
        PH_JLENHI: cnt_p = {b, 8'h00};
        PH_JLENLO: begin
          if (len < 16'd2) begin
            emit_byte = 1'b1;
            r_type    = IMG_JPEG;
            r_stat    = ST_BAD_LENGTH;
          end else begin
            cnt_p = len_m2;
          end
        end
        PH_JSKIP: cnt_p = cnt_dec;
        PH_JSOF: begin
          cnt_p = cnt_r + 16'd1;
          case (cnt_r)
            SOF_H_HI: hacc_p[15:8] = b;
            SOF_H_LO: hacc_p[7:0]  = b;
            SOF_W_HI: wacc_p[15:8] = b;
            SOF_W_LO: begin
              wacc_p[7:0] = b;
              cnt_p       = cnt_r;
              emit_byte   = 1'b1;
              r_type      = IMG_JPEG;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    emit           = emit_byte;
    res.image_type = r_type;
    res.status     = r_stat;
    res.width      = '0;
    res.height     = '0;
    if (emit_byte && (r_stat == ST_OK) && (r_type != IMG_ART)) begin
      res.width  = wacc_p;
      res.height = hacc_p;
    end
    // end of file with nothing reported yet
    if (eof && !sent_r && !emit_byte) begin
      emit           = 1'b1;
      res.image_type = type_p;
      res.status     = ((phase_p == PH_JSEARCH) || (phase_p == PH_JCODE)) ?
                       ST_NO_FRAME : ST_TRUNCATED;
    end
  end

  assign fire     = item_vld && (!emit || out_free);
  assign take     = fire;
  assign res_load = fire && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= '0;
      type_r  <= IMG_UNKNOWN;
      phase_r <= PH_SIG;
      cnt_r   <= '0;
      wacc_r  <= '0;
      hacc_r  <= '0;
      sent_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      if (eof) begin
        off_r  <= '0;
        type_r <= IMG_UNKNOWN;
        cnt_r  <= '0;
        wacc_r <= '0;
        hacc_r <= '0;
        sent_r <= 1'b0;
      end else begin
        if (off_r != OFS_MAX) begin
          off_r <= off_r + 5'd1;
        end
        type_r <= type_p;
        cnt_r  <= cnt_p;
        wacc_r <= wacc_p;
        hacc_r <= hacc_p;
        sent_r <= sent_r || emit;
      end
    end
  end

  // first two signature bytes, read only at offset two
  always_ff @(posedge clk) begin
    if (fire && (off_r == 5'd0)) begin
      sig0_r <= b;
    end
    if (fire && (off_r == 5'd1)) begin
      sig1_r <= b;
    end
  end

endmodule

>>> rtl/core/ihsp_out_reg.sv
`timescale 1ns / 1ps
// result register driving the result channel
module ihsp_out_reg
  import ihsp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_load,
  input  result_t       res,
  output logic          out_free,
  ihsp_result_if.source out_chan
);

  logic    vld_r;
  result_t res_r;

  assign out_free = !vld_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_load) begin
      vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid      = vld_r;
  assign out_chan.image_type = res_r.image_type;
  assign out_chan.status     = res_r.status;
  assign out_chan.width      = res_r.width;
  assign out_chan.height     = res_r.height;

endmodule

>>> rtl/core/image_header_size_parser.sv
`timescale 1ns / 1ps
// Image header size parser: takes an image file one byte per request, in file order, with
// end_of_file on the last byte, and returns one result per file holding the image type,
// a status and the width and height (zero on failure and for art). A byte is taken every
// clock cycle; a byte waits in the input register, and its result, if any, goes to the
// result register as the parse stage takes it. The single parse stage sets the rate:
// it only holds a byte back while a result is due and the result register is occupied.
// Bytes after a file's result are consumed and dropped until end_of_file.
module image_header_size_parser
  import ihsp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  ihsp_byte_if.sink     in_chan,
  ihsp_result_if.source out_chan
);

  logic     item_vld;
  in_item_t item;
  logic     take;
  logic     res_load;
  result_t  res;
  logic     out_free;

  ihsp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .take     (take),
    .item_vld (item_vld),
    .item     (item)
  );

  ihsp_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (item_vld),
    .item     (item),
    .out_free (out_free),
    .take     (take),
    .res_load (res_load),
    .res      (res)
  );

  ihsp_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_load (res_load),
    .res      (res),
    .out_free (out_free),
    .out_chan (out_chan)
  );

endmodule

>>> rtl/core/ihsp_checker.sv
`timescale 1ns / 1ps
// port-level checker for the image header size parser and its bind
module ihsp_checker
  import ihsp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_image_type,
  input logic [2:0]         out_status,
  input logic signed [31:0] out_width,
  input logic signed [31:0] out_height
);

  // both sides come out of reset empty and ready for bytes
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && in_ready)
    else $error("result pending or input blocked right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_image_type) &&
      $stable(out_status) && $stable(out_width) && $stable(out_height))
    else $error("stalled result changed");

  a_ok_has_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) |-> out_image_type != IMG_UNKNOWN)
    else $error("ok status with unknown type");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_width == 0) && (out_height == 0))
    else $error("failed result carries dimensions");

endmodule

bind image_header_size_parser ihsp_checker u_ihsp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_image_type (out_chan.image_type),
  .out_status     (out_chan.status),
  .out_width      (out_chan.width),
  .out_height     (out_chan.height)
);
